FILE: sv/assert_macros.svh
// Assertion macros shared by the rotate address generator RTL.
// No dependencies; define SYNTH to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, disabled while the active-low reset is asserted.
`define RAG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("rag assertion failed");
// Clocked check that also runs during reset.
`define RAG_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rag assertion failed");
`else
`define RAG_ASSERT(lbl, clk, rstn, prop)
`define RAG_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: sv/rag_pkg.sv
// Shared widths, register indexes and the pixel struct of the rotate address generator.
// No dependencies.
`timescale 1ns / 1ps
package rag_pkg;
    localparam int CNT_W      = 11;   // destination column / row
    localparam int PIXN_W     = 12;   // pixel count per axis, 1 .. MAX_PIX
    localparam int MAX_PIX    = 2048;
    localparam int SRC_W      = 10;   // source column / row
    localparam int DIM_W      = 11;   // source width / height register
    localparam int ANG_RAW_W  = 16;   // sine / cosine register
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int BOX_LAT    = 5;    // stages of the bounding box unit
    localparam int SETTLE_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 4'd0,
        CFG_SRC_HEIGHT = 4'd1,
        CFG_SINE       = 4'd2,
        CFG_COSINE     = 4'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] dst_x;
        logic [CNT_W-1:0] dst_y;
        logic             last;
    } rag_pix_t;
endpackage

FILE: sv/rag_box.sv
// Bounding box unit: rotated corners, box offsets and pixel counts, five stages.
// Depends on rag_pkg.
`timescale 1ns / 1ps
module rag_box #(
    parameter int  ANGLE_FRAC_BITS = 14,
    localparam int ANG_W = ANGLE_FRAC_BITS + 2,
    localparam int BOX_W = ANGLE_FRAC_BITS + 15
) (
    input  logic                           aclk,
    input  logic [rag_pkg::DIM_W-1:0]      w_dim,
    input  logic [rag_pkg::DIM_W-1:0]      h_dim,
    input  logic signed [ANG_W-1:0]        s_ang,
    input  logic signed [ANG_W-1:0]        c_ang,
    output logic signed [BOX_W-1:0]        box_min_x,
    output logic signed [BOX_W-1:0]        box_min_y,
    output logic [rag_pkg::PIXN_W-1:0]     box_cols,
    output logic [rag_pkg::PIXN_W-1:0]     box_rows
);
    import rag_pkg::*;

    localparam int F      = ANGLE_FRAC_BITS;
    localparam int PROD_W = DIM_W + 1 + ANG_W;
    localparam int SIZE_W = PROD_W + 2;
    localparam int N_W    = SIZE_W + 1 - F;
    localparam int ONE_M1 = (1 << F) - 1;

    logic signed [PROD_W-1:0] hs_reg, hc_reg, wc_reg, ws_reg;
    logic signed [BOX_W-1:0]  x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [BOX_W-1:0]  mnx_reg, mxx_reg, mny_reg, mxy_reg;
    logic signed [BOX_W-1:0]  min_x_reg, min_y_reg;
    logic [SIZE_W-1:0]        size_x_reg, size_y_reg;
    logic [PIXN_W-1:0]        cols_reg, rows_reg;

    function automatic logic signed [BOX_W-1:0] min4(input logic signed [BOX_W-1:0] b,
                                                     input logic signed [BOX_W-1:0] c,
                                                     input logic signed [BOX_W-1:0] d);
        logic signed [BOX_W-1:0] m;
        m = '0;
        if (b < m) m = b;
        if (c < m) m = c;
        if (d < m) m = d;
        return m;
    endfunction

    function automatic logic signed [BOX_W-1:0] max4(input logic signed [BOX_W-1:0] b,
                                                     input logic signed [BOX_W-1:0] c,
                                                     input logic signed [BOX_W-1:0] d);
        logic signed [BOX_W-1:0] m;
        m = '0;
        if (b > m) m = b;
        if (c > m) m = c;
        if (d > m) m = d;
        return m;
    endfunction

    // Round a Q.F size up to whole pixels, at least one, at most MAX_PIX.
    function automatic logic [PIXN_W-1:0] pixel_count(input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0]   rnd;
        logic [N_W-1:0]    n;
        logic [PIXN_W-1:0] res;
        rnd = {1'b0, size} + (SIZE_W + 1)'(ONE_M1);
        n   = rnd[SIZE_W:F];
        if (n == '0) begin
            res = PIXN_W'(1);
        end else if (n > N_W'(MAX_PIX)) begin
            res = PIXN_W'(MAX_PIX);
        end else begin
            res = PIXN_W'(n);
        end
        return res;
    endfunction

    always_ff @(posedge aclk) begin
        // corner products
        hs_reg <= PROD_W'($signed({1'b0, h_dim})) * PROD_W'(s_ang);
        hc_reg <= PROD_W'($signed({1'b0, h_dim})) * PROD_W'(c_ang);
        wc_reg <= PROD_W'($signed({1'b0, w_dim})) * PROD_W'(c_ang);
        ws_reg <= PROD_W'($signed({1'b0, w_dim})) * PROD_W'(s_ang);
        // corners (w,0) (0,h) (w,h)
        x1_reg <= -BOX_W'(hs_reg);
        y1_reg <= BOX_W'(hc_reg);
        x2_reg <= BOX_W'(wc_reg) - BOX_W'(hs_reg);
        y2_reg <= BOX_W'(hc_reg) + BOX_W'(ws_reg);
        x3_reg <= BOX_W'(wc_reg);
        y3_reg <= BOX_W'(ws_reg);
        // extent including the origin
        mnx_reg <= min4(x1_reg, x2_reg, x3_reg);
        mxx_reg <= max4(x1_reg, x2_reg, x3_reg);
        mny_reg <= min4(y1_reg, y2_reg, y3_reg);
        mxy_reg <= max4(y1_reg, y2_reg, y3_reg);
        min_x_reg  <= mnx_reg;
        min_y_reg  <= mny_reg;
        size_x_reg <= SIZE_W'(mxx_reg) - SIZE_W'(mnx_reg);
        size_y_reg <= SIZE_W'(mxy_reg) - SIZE_W'(mny_reg);
        cols_reg   <= pixel_count(size_x_reg);
        rows_reg   <= pixel_count(size_y_reg);
    end

    assign box_min_x = min_x_reg;
    assign box_min_y = min_y_reg;
    assign box_cols  = cols_reg;
    assign box_rows  = rows_reg;
endmodule

FILE: sv/rag_scan.sv
// Raster scan: active box, column / row counters and the input register stage.
// Depends on rag_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rag_scan #(
    parameter int  ANGLE_FRAC_BITS = 14,
    localparam int BOX_W = ANGLE_FRAC_BITS + 15
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_start_req,
    input  logic                        box_ready,
    input  logic signed [BOX_W-1:0]     box_min_x,
    input  logic signed [BOX_W-1:0]     box_min_y,
    input  logic [rag_pkg::PIXN_W-1:0]  box_cols,
    input  logic [rag_pkg::PIXN_W-1:0]  box_rows,
    output logic                        s1_valid,
    input  logic                        s1_ready,
    output rag_pkg::rag_pix_t           s1_pix,
    output logic signed [BOX_W-1:0]     s1_min_x,
    output logic signed [BOX_W-1:0]     s1_min_y
);
    import rag_pkg::*;

    logic [CNT_W-1:0]        col_reg, row_reg, col_next, row_next, col_use, row_use;
    logic [PIXN_W-1:0]       cols_reg, rows_reg, cols_use, rows_use, col_inc, row_inc;
    logic signed [BOX_W-1:0] min_x_reg, min_y_reg, min_x_use, min_y_use;
    logic                    s1_valid_reg, accept, last_use;
    rag_pix_t                pix_reg;
    logic signed [BOX_W-1:0] s1_min_x_reg, s1_min_y_reg;

    assign s_ready = box_ready && (!s1_valid_reg || s1_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (s_start_req) begin
            cols_use  = box_cols;
            rows_use  = box_rows;
            min_x_use = box_min_x;
            min_y_use = box_min_y;
            col_use   = '0;
            row_use   = '0;
        end else begin
            cols_use  = cols_reg;
            rows_use  = rows_reg;
            min_x_use = min_x_reg;
            min_y_use = min_y_reg;
            col_use   = col_reg;
            row_use   = row_reg;
        end
        last_use = ({1'b0, col_use} == cols_use - PIXN_W'(1))
                && ({1'b0, row_use} == rows_use - PIXN_W'(1));
        col_inc  = {1'b0, col_use} + PIXN_W'(1);
        row_inc  = {1'b0, row_use} + PIXN_W'(1);
        col_next = col_inc[CNT_W-1:0];
        row_next = row_use;
        if (col_inc >= cols_use) begin
            col_next = '0;
            row_next = (row_inc >= rows_use) ? '0 : row_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            cols_reg     <= PIXN_W'(1);
            rows_reg     <= PIXN_W'(1);
            min_x_reg    <= '0;
            min_y_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                cols_reg  <= cols_use;
                rows_reg  <= rows_use;
                min_x_reg <= min_x_use;
                min_y_reg <= min_y_use;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg.dst_x <= col_use;
            pix_reg.dst_y <= row_use;
            pix_reg.last  <= last_use;
            s1_min_x_reg  <= min_x_use;
            s1_min_y_reg  <= min_y_use;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_pix   = pix_reg;
    assign s1_min_x = s1_min_x_reg;
    assign s1_min_y = s1_min_y_reg;

    `RAG_ASSERT(a_col_in_box, aclk, aresetn, {1'b0, col_reg} < cols_reg)
    `RAG_ASSERT(a_row_in_box, aclk, aresetn, {1'b0, row_reg} < rows_reg)
    `RAG_ASSERT(a_start_origin, aclk, aresetn, s_valid && s_ready && s_start_req |=> s1_valid_reg && (pix_reg.dst_x == '0) && (pix_reg.dst_y == '0))
endmodule

FILE: sv/rag_map.sv
// Inverse rotation datapath: offset add, four products, sum and bounds test, result register.
// Depends on rag_pkg.
`timescale 1ns / 1ps
module rag_map #(
    parameter int  ANGLE_FRAC_BITS = 14,
    localparam int ANG_W = ANGLE_FRAC_BITS + 2,
    localparam int BOX_W = ANGLE_FRAC_BITS + 15
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s1_valid,
    output logic                         s1_ready,
    input  rag_pkg::rag_pix_t            s1_pix,
    input  logic signed [BOX_W-1:0]      s1_min_x,
    input  logic signed [BOX_W-1:0]      s1_min_y,
    input  logic [rag_pkg::DIM_W-1:0]    w_dim,
    input  logic [rag_pkg::DIM_W-1:0]    h_dim,
    input  logic signed [ANG_W-1:0]      s_ang,
    input  logic signed [ANG_W-1:0]      c_ang,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rag_pkg::CNT_W-1:0]    m_dst_x,
    output logic [rag_pkg::CNT_W-1:0]    m_dst_y,
    output logic [rag_pkg::SRC_W-1:0]    m_src_x,
    output logic [rag_pkg::SRC_W-1:0]    m_src_y,
    output logic                         m_inside_res,
    output logic                         m_last_pixel
);
    import rag_pkg::*;

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int J_W   = ((BOX_W > CNT_W + F + 1) ? BOX_W : CNT_W + F + 1) + 1;
    localparam int MUL_W = J_W + ANG_W;
    localparam int SUM_W = MUL_W + 1;
    localparam int PX_W  = SUM_W - 2 * F;

    logic                    s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic                    s2_ready, s3_ready, out_free;
    rag_pix_t                pix2_reg, pix3_reg;
    logic signed [J_W-1:0]   jx_reg, iy_reg;
    logic signed [MUL_W-1:0] jxc_reg, iys_reg, iyc_reg, jxs_reg;
    logic signed [SUM_W-1:0] sx, sy;
    logic [PX_W-1:0]         px, py;
    logic                    src_hit;
    logic [CNT_W-1:0]        dst_x_reg, dst_y_reg;
    logic [SRC_W-1:0]        src_x_reg, src_y_reg;
    logic                    inside_reg, last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s3_ready = !s3_valid_reg || out_free;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = s2_ready;

    always_comb begin
        sx = SUM_W'(jxc_reg) + SUM_W'(iys_reg);
        sy = SUM_W'(iyc_reg) - SUM_W'(jxs_reg);
        px = sx[SUM_W-1:2*F];
        py = sy[SUM_W-1:2*F];
        src_hit = !sx[SUM_W-1] && !sy[SUM_W-1]
               && (px < PX_W'(w_dim)) && (py < PX_W'(h_dim));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s2_ready) s2_valid_reg <= s1_valid;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (out_free) m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            pix2_reg <= s1_pix;
            jx_reg   <= $signed(J_W'(s1_pix.dst_x) << F) + J_W'(s1_min_x);
            iy_reg   <= $signed(J_W'(s1_pix.dst_y) << F) + J_W'(s1_min_y);
        end
        if (s3_ready) begin
            pix3_reg <= pix2_reg;
            jxc_reg  <= MUL_W'(jx_reg) * MUL_W'(c_ang);
            iys_reg  <= MUL_W'(iy_reg) * MUL_W'(s_ang);
            iyc_reg  <= MUL_W'(iy_reg) * MUL_W'(c_ang);
            jxs_reg  <= MUL_W'(jx_reg) * MUL_W'(s_ang);
        end
        if (out_free) begin
            dst_x_reg  <= pix3_reg.dst_x;
            dst_y_reg  <= pix3_reg.dst_y;
            last_reg   <= pix3_reg.last;
            inside_reg <= src_hit;
            src_x_reg  <= src_hit ? px[SRC_W-1:0] : '0;
            src_y_reg  <= src_hit ? py[SRC_W-1:0] : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dst_x      = dst_x_reg;
    assign m_dst_y      = dst_y_reg;
    assign m_src_x      = src_x_reg;
    assign m_src_y      = src_y_reg;
    assign m_inside_res = inside_reg;
    assign m_last_pixel = last_reg;
endmodule

FILE: sv/rotate_address_generator_unit.sv
// Top level of the rotate address generator: configuration registers, settle control.
// Depends on rag_pkg, rag_box, rag_scan, rag_map and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage
//   Configuration: write src_width, src_height, sine, cosine (Q1.14 by default)
//   through cfg_valid / cfg_index / cfg_wdata while the block is idle. cfg_ready
//   is always high. Every write restarts the bounding box unit, and s_ready stays
//   low while the box offsets and pixel counts settle.
//   Input channel: each accepted item either restarts the raster (s_start_req = 1,
//   box latched from the settled configuration, pixel (0,0) emitted) or advances
//   one pixel in raster order; the scan wraps after the last pixel.
//   Result channel: one item per input item with destination and source
//   coordinates, inside flag and last-pixel marker.
//   Result path: each accepted item is registered in the input stage, then in the
//   offset add, multiply, and sum with bounds test stages before it is valid.
//   Throughput: one item per cycle when not stalled; the four signed products in
//   the multiply stage set the clock, as the corner products do in the box unit.
//   Stall: each stage holds its item while the next one is full, so items keep
//   flowing into free stages while m_ready is low; nothing is dropped.
//   Reset: synchronous, active low. Registers return to their reset values,
//   the scan sits at (0,0) on a one-by-one box, and s_ready stays low after reset
//   is released until the box settles.
module rotate_address_generator_unit #(
    parameter int MAX_SRC_DIM     = 1024,
    parameter int ANGLE_FRAC_BITS = 14
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rag_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rag_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_start_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rag_pkg::CNT_W-1:0]       m_dst_x,
    output logic [rag_pkg::CNT_W-1:0]       m_dst_y,
    output logic [rag_pkg::SRC_W-1:0]       m_src_x,
    output logic [rag_pkg::SRC_W-1:0]       m_src_y,
    output logic                            m_inside_res,
    output logic                            m_last_pixel
);
    import rag_pkg::*;

    localparam int F       = ANGLE_FRAC_BITS;
    localparam int ANG_W   = F + 2;
    localparam int BOX_W   = F + 15;
    localparam int ANG_ONE = 1 << F;

    logic [DIM_W-1:0]            src_width_reg, src_height_reg;
    logic signed [ANG_RAW_W-1:0] sine_reg, cosine_reg;
    logic [SETTLE_W-1:0]         settle_reg;
    logic                        cfg_write, box_ready;
    logic [DIM_W-1:0]            w_dim, h_dim;
    logic signed [ANG_W-1:0]     s_ang, c_ang;
    logic signed [BOX_W-1:0]     box_min_x, box_min_y, s1_min_x, s1_min_y;
    logic [PIXN_W-1:0]           box_cols, box_rows;
    logic                        s1_valid, s1_ready;
    rag_pix_t                    s1_pix;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign box_ready = (settle_reg == '0);

    // Register file; writes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_W'(1);
            src_height_reg <= DIM_W'(1);
            sine_reg       <= '0;
            cosine_reg     <= ANG_RAW_W'(16384);
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_SINE:       sine_reg       <= cfg_wdata;
                CFG_COSINE:     cosine_reg     <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Hold off new items until the box unit has seen the current settings.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write) begin
            settle_reg <= SETTLE_W'(BOX_LAT);
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - SETTLE_W'(1);
        end
    end

    // Saturate dimensions to the supported size and the angle to +-1.0.
    always_comb begin
        w_dim = (int'(src_width_reg) > MAX_SRC_DIM) ? DIM_W'(MAX_SRC_DIM) : src_width_reg;
        h_dim = (int'(src_height_reg) > MAX_SRC_DIM) ? DIM_W'(MAX_SRC_DIM) : src_height_reg;
        if (int'(sine_reg) > ANG_ONE) begin
            s_ang = ANG_W'(ANG_ONE);
        end else if (int'(sine_reg) < -ANG_ONE) begin
            s_ang = ANG_W'(-ANG_ONE);
        end else begin
            s_ang = ANG_W'(sine_reg);
        end
        if (int'(cosine_reg) > ANG_ONE) begin
            c_ang = ANG_W'(ANG_ONE);
        end else if (int'(cosine_reg) < -ANG_ONE) begin
            c_ang = ANG_W'(-ANG_ONE);
        end else begin
            c_ang = ANG_W'(cosine_reg);
        end
    end

    rag_box #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_box (
        .aclk      (aclk),
        .w_dim     (w_dim),
        .h_dim     (h_dim),
        .s_ang     (s_ang),
        .c_ang     (c_ang),
        .box_min_x (box_min_x),
        .box_min_y (box_min_y),
        .box_cols  (box_cols),
        .box_rows  (box_rows)
    );

    rag_scan #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .box_ready   (box_ready),
        .box_min_x   (box_min_x),
        .box_min_y   (box_min_y),
        .box_cols    (box_cols),
        .box_rows    (box_rows),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_pix      (s1_pix),
        .s1_min_x    (s1_min_x),
        .s1_min_y    (s1_min_y)
    );

    rag_map #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_map (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_pix       (s1_pix),
        .s1_min_x     (s1_min_x),
        .s1_min_y     (s1_min_y),
        .w_dim        (w_dim),
        .h_dim        (h_dim),
        .s_ang        (s_ang),
        .c_ang        (c_ang),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dst_x      (m_dst_x),
        .m_dst_y      (m_dst_y),
        .m_src_x      (m_src_x),
        .m_src_y      (m_src_y),
        .m_inside_res (m_inside_res),
        .m_last_pixel (m_last_pixel)
    );

    `RAG_ASSERT(a_cfg_blocks_input, aclk, aresetn, cfg_valid && cfg_ready |=> !s_ready)
    `RAG_ASSERT(a_outside_zero, aclk, aresetn, m_valid && !m_inside_res |-> (m_src_x == '0) && (m_src_y == '0))
    `RAG_ASSERT_NR(a_reset_holds_input, aclk, !aresetn |=> !s_ready)
endmodule

FILE: tb/rotate_address_generator_unit_test.sv
// Self-checking testbench for rotate_address_generator_unit: random and directed rasters.
// Depends on rag_pkg and the rotate_address_generator_unit RTL; needs no files at run time.
`timescale 1ns / 1ps
module rotate_address_generator_unit_test;
    import rag_pkg::*;

    localparam int FRAC_BITS   = 14;
    localparam int SRC_DIM_MAX = 1024;
    localparam int DRAIN_PAUSE = 8;     // a little over the pipeline depth

    // One destination pixel as it leaves the block.
    typedef struct packed {
        logic [CNT_W-1:0] dst_x;
        logic [CNT_W-1:0] dst_y;
        logic [SRC_W-1:0] src_x;
        logic [SRC_W-1:0] src_y;
        logic             in_image;
        logic             last;
    } pixel_addr_t;

    // Raster predictor plus the queue of pixels still owed by the block.
    class raster_scoreboard;
        logic [DIM_W-1:0]     width_reg;
        logic [DIM_W-1:0]     height_reg;
        logic [ANG_RAW_W-1:0] sine_reg;
        logic [ANG_RAW_W-1:0] cosine_reg;
        longint               col_idx, row_idx;
        longint               box_x0, box_y0, box_w, box_h;
        pixel_addr_t          owed_q[$];
        int unsigned          mismatches;

        function new();
            width_reg  = 1;
            height_reg = 1;
            sine_reg   = '0;
            cosine_reg = 16'd16384;
            col_idx    = 0;
            row_idx    = 0;
            box_x0     = 0;
            box_y0     = 0;
            box_w      = 0;
            box_h      = 0;
            mismatches = 0;
        endfunction

        function longint dim_sat(logic [DIM_W-1:0] raw);
            return (raw > SRC_DIM_MAX) ? SRC_DIM_MAX : longint'(raw);
        endfunction

        function longint angle_sat(logic [ANG_RAW_W-1:0] raw);
            longint lim;
            longint v;
            lim = longint'(1) << FRAC_BITS;
            v = longint'($signed(raw));
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            return v;
        endfunction

        // Round a Q.F box size up to whole pixels, at least one and at most MAX_PIX.
        function longint pixel_span(longint size);
            longint n;
            n = (size + (longint'(1) << FRAC_BITS) - 1) >>> FRAC_BITS;
            if (n == 0) n = 1;
            if (n > MAX_PIX) n = MAX_PIX;
            return n;
        endfunction

        function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SRC_WIDTH:  width_reg  = data[DIM_W-1:0];
                CFG_SRC_HEIGHT: height_reg = data[DIM_W-1:0];
                CFG_SINE:       sine_reg   = data;
                CFG_COSINE:     cosine_reg = data;
                default: ;
            endcase
        endfunction

        // Predict the pixel caused by one accepted request and queue it.
        function void note_request(logic start);
            longint w, h, s, c, cols, rows, jx, iy, sx, sy, px, py;
            longint xs[4], ys[4];
            longint mnx, mxx, mny, mxy;
            pixel_addr_t pix;
            w = dim_sat(width_reg);
            h = dim_sat(height_reg);
            s = angle_sat(sine_reg);
            c = angle_sat(cosine_reg);
            if (start) begin
                // Rotated corners (0,h), (w,h), (w,0); the origin is always in the box.
                xs = '{0, -h * s, w * c - h * s, w * c};
                ys = '{0, h * c, h * c + w * s, w * s};
                mnx = 0; mxx = 0; mny = 0; mxy = 0;
                foreach (xs[k]) begin
                    if (xs[k] < mnx) mnx = xs[k];
                    if (xs[k] > mxx) mxx = xs[k];
                    if (ys[k] < mny) mny = ys[k];
                    if (ys[k] > mxy) mxy = ys[k];
                end
                box_x0 = mnx;
                box_y0 = mny;
                box_w  = mxx - mnx;
                box_h  = mxy - mny;
                col_idx = 0;
                row_idx = 0;
            end
            cols = pixel_span(box_w);
            rows = pixel_span(box_h);
            if (col_idx >= cols) col_idx = 0;
            if (row_idx >= rows) row_idx = 0;

            jx = (col_idx << FRAC_BITS) + box_x0;
            iy = (row_idx << FRAC_BITS) + box_y0;
            sx = jx * c + iy * s;
            sy = iy * c - jx * s;

            pix = '0;
            pix.dst_x = col_idx[CNT_W-1:0];
            pix.dst_y = row_idx[CNT_W-1:0];
            if (sx >= 0 && sy >= 0) begin
                px = sx >>> (2 * FRAC_BITS);
                py = sy >>> (2 * FRAC_BITS);
                if (px < w && py < h) begin
                    pix.in_image = 1'b1;
                    pix.src_x = px[SRC_W-1:0];
                    pix.src_y = py[SRC_W-1:0];
                end
            end
            pix.last = (col_idx == cols - 1) && (row_idx == rows - 1);
            owed_q.push_back(pix);

            col_idx++;
            if (col_idx >= cols) begin
                col_idx = 0;
                row_idx++;
                if (row_idx >= rows) row_idx = 0;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_pixel(pixel_addr_t got);
            pixel_addr_t want;
            if (owed_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected pixel, expected none, actual %p", $time, got);
                return;
            end
            want = owed_q.pop_front();
            compare_field("dst_x", want.dst_x, got.dst_x);
            compare_field("dst_y", want.dst_y, got.dst_y);
            compare_field("src_x", want.src_x, got.src_x);
            compare_field("src_y", want.src_y, got.src_y);
            compare_field("inside_res", want.in_image, got.in_image);
            compare_field("last_pixel", want.last, got.last);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_start_req = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CNT_W-1:0]      m_dst_x, m_dst_y;
    logic [SRC_W-1:0]      m_src_x, m_src_y;
    logic                  m_inside_res, m_last_pixel;

    // Idle odds in percent for the request and pixel sides.
    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 60;

    raster_scoreboard board;

    rotate_address_generator_unit #(
        .MAX_SRC_DIM    (SRC_DIM_MAX),
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dst_x     (m_dst_x),
        .m_dst_y     (m_dst_y),
        .m_src_x     (m_src_x),
        .m_src_y     (m_src_y),
        .m_inside_res(m_inside_res),
        .m_last_pixel(m_last_pixel)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Ready toggles on the falling edge so that stalls land on every pipeline phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sample pixels on the rising edge; values seen here are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_pixel('{m_dst_x, m_dst_y, m_src_x, m_src_y, m_inside_res,
                                m_last_pixel});
        end
    end

    // Offer one request item; return on the falling edge after it is taken.
    task automatic push_request(input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            s_start_req = $urandom_range(1);
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_start_req = start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(start);
        @(negedge aclk);
    endtask

    // Drop valid and hold off until every owed pixel has come out.
    task automatic hold_until_drained();
        s_valid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_register(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Reprogram size and angle; only legal once the block has gone quiet.
    task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [ANG_RAW_W-1:0] s, input logic [ANG_RAW_W-1:0] c);
        hold_until_drained();
        write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_SINE, s);
        write_reg(CFG_COSINE, c);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return DIM_W'($urandom_range(6, 1));
        if (r < 88) return DIM_W'($urandom_range(40, 7));
        if (r < 92) return '0;
        if (r < 96) return DIM_W'($urandom_range(2047, 1000));
        return DIM_W'($urandom_range(2047));
    endfunction

    function automatic logic [ANG_RAW_W-1:0] pick_angle();
        int unsigned r;
        int v;
        r = $urandom_range(99);
        if (r < 30) begin
            // Cardinal and common angles.
            case ($urandom_range(6))
                0: v = 0;
                1: v = 16384;
                2: v = -16384;
                3: v = 11585;
                4: v = -11585;
                5: v = 8192;
                default: v = 14189;
            endcase
        end else if (r < 92) begin
            v = int'($urandom_range(32768)) - 16384;
        end else begin
            // Any raw 16-bit value, often beyond +-1.0, to exercise saturation.
            v = int'($urandom_range(65535));
        end
        return ANG_RAW_W'(v);
    endfunction

    // Extremes, angles in three quadrants and corner cases, one short raster at a time.
    task automatic run_directed();
        // Advance before any start: reset box is a single pixel at the origin.
        push_request(1'b0);
        push_request(1'b0);
        // Start with reset registers.
        push_request(1'b1);
        push_request(1'b0);
        // Unrotated 3x2 image: walk past the last pixel to see the wrap.
        configure(11'd3, 11'd2, 16'd0, 16'd16384);
        push_request(1'b1);
        repeat (6) push_request(1'b0);
        // Quarter turn.
        configure(11'd4, 11'd3, 16'd16384, 16'd0);
        push_request(1'b1);
        repeat (3) push_request(1'b0);
        // Negative sine and cosine at full scale.
        configure(11'd5, 11'd2, 16'hC000, 16'hC000);
        push_request(1'b1);
        repeat (2) push_request(1'b0);
        // Oversized width, zero height, angle registers beyond range.
        configure(11'd2047, 11'd0, 16'h8000, 16'h7FFF);
        push_request(1'b1);
        repeat (2) push_request(1'b0);
        // Empty box still gives one pixel.
        configure(11'd0, 11'd0, 16'd11585, 16'd11585);
        push_request(1'b1);
        push_request(1'b0);
        // Largest image and widest box.
        configure(11'd1024, 11'd1024, 16'd16384, 16'd16384);
        push_request(1'b1);
        push_request(1'b0);
    endtask

    // One raster with fresh settings; now and then skip the start or restart mid-scan.
    task automatic random_segment(input int n_items);
        bit lead_start;
        int pause_at;
        configure(pick_dim(), pick_dim(), pick_angle(), pick_angle());
        lead_start = ($urandom_range(9) != 0);
        pause_at = ($urandom_range(5) == 0) ? int'($urandom_range(n_items - 1)) : -1;
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at) hold_until_drained();
            push_request((i == 0 && lead_start) || ($urandom_range(99) < 4));
        end
    endtask

    initial begin
        int sent_in_phase;
        int n;
        board = new();
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 9;  recv_idle_pct = 60; end
                1: begin send_idle_pct = 60; recv_idle_pct = 9;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 0) run_directed();
            sent_in_phase = 0;
            while (sent_in_phase < 360) begin
                n = $urandom_range(80, 10);
                random_segment(n);
                sent_in_phase += n;
            end
        end

        hold_until_drained();
        repeat (10) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/rag_pkg.sv
sv/rag_box.sv
sv/rag_scan.sv
sv/rag_map.sv
sv/rotate_address_generator_unit.sv
tb/rotate_address_generator_unit_test.sv
